// ===== rtl/core/iesa_pkg.sv =====
// package: event and report types, event codes and config register indexes
`default_nettype none
package iesa_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_HAS_PRESSURE_AXIS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOUCH_LEVEL       = 1'd1;

  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_REL = 5'd2;
  localparam logic [4:0] EV_ABS = 5'd3;

  localparam logic [9:0] SYN_RPT = 10'h000;

  localparam logic [9:0] REL_X = 10'h000;
  localparam logic [9:0] REL_Y = 10'h001;

  localparam logic [9:0] ABS_X     = 10'h000;
  localparam logic [9:0] ABS_Y     = 10'h001;
  localparam logic [9:0] ABS_PRESS = 10'h018;
  localparam logic [9:0] ABS_WIDTH = 10'h01C;

  localparam logic [9:0] KEY_EXTRA_FIRST = 10'h100;
  localparam logic [9:0] KEY_EXTRA_LAST  = 10'h107;
  localparam logic [9:0] KEY_LEFT        = 10'h110;
  localparam logic [9:0] KEY_RIGHT       = 10'h111;
  localparam logic [9:0] KEY_MIDDLE      = 10'h112;
  localparam logic [9:0] KEY_UP          = 10'h115;
  localparam logic [9:0] KEY_DOWN        = 10'h116;
  localparam logic [9:0] KEY_AUX_LEFT    = 10'h130;
  localparam logic [9:0] KEY_AUX_RIGHT   = 10'h131;
  localparam logic [9:0] KEY_TOOL_ONE    = 10'h145;
  localparam logic [9:0] KEY_TOUCH       = 10'h14A;
  localparam logic [9:0] KEY_TOOL_TWO    = 10'h14D;
  localparam logic [9:0] KEY_TOOL_THREE  = 10'h14E;

  localparam int unsigned MAIN_LEFT   = 0;
  localparam int unsigned MAIN_RIGHT  = 1;
  localparam int unsigned MAIN_MIDDLE = 2;
  localparam int unsigned MAIN_UP     = 3;
  localparam int unsigned MAIN_DOWN   = 4;

  localparam int unsigned AUX_LEFT  = 0;
  localparam int unsigned AUX_RIGHT = 1;

  localparam int unsigned TOOL_ONE   = 0;
  localparam int unsigned TOOL_TWO   = 1;
  localparam int unsigned TOOL_THREE = 2;

  typedef struct packed {
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
  } evt_t;

  typedef struct packed {
    logic signed [31:0] rep_x;
    logic signed [31:0] rep_y;
    logic signed [31:0] rep_pressure;
    logic signed [31:0] rep_width;
    logic [1:0]         rep_fingers;
    logic [4:0]         rep_main_buttons;
    logic [7:0]         rep_extra_buttons;
    logic [1:0]         rep_guest_buttons;
    logic signed [31:0] rep_rel_dx;
    logic signed [31:0] rep_rel_dy;
  } rep_t;

  typedef struct packed {
    logic        has_pressure_axis;
    logic [15:0] touch_level;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/iesa_if.sv =====
// interfaces: event input channel and report output channel
`default_nettype none
interface iesa_evt_if
  import iesa_pkg::*;
;
  logic valid;
  logic ready;
  evt_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iesa_rep_if
  import iesa_pkg::*;
;
  logic valid;
  logic ready;
  rep_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/iesa_in_stage.sv =====
// input register: holds one event until the decode stage takes it
`default_nettype none
module iesa_in_stage
  import iesa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire evt_t in_evt,
  output logic      in_ready,
  input  wire logic go,
  output logic      evt_valid,
  output evt_t      evt
);

  logic evt_valid_r;
  logic evt_valid_nxt;
  evt_t evt_r;

  assign in_ready      = !evt_valid_r || go;
  assign evt_valid_nxt = in_ready ? in_valid : evt_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_valid_r <= 1'b0;
    end else begin
      evt_valid_r <= evt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      evt_r <= in_evt;
    end
  end

  assign evt_valid = evt_valid_r;
  assign evt       = evt_r;

endmodule
`default_nettype wire

// ===== rtl/core/iesa_decode.sv =====
// decode stage: folds events into held state and forms the report snapshot
`default_nettype none
module iesa_decode
  import iesa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire evt_t evt,
  input  wire logic go,
  output logic      is_report,
  output rep_t      rep
);

  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic signed [31:0] pressure_r, pressure_nxt;
  logic signed [31:0] width_r, width_nxt;
  logic [4:0]         main_r, main_nxt;
  logic [7:0]         extra_r, extra_nxt;
  logic [1:0]         guest_r, guest_nxt;
  logic [2:0]         tool_r, tool_nxt;
  logic signed [31:0] dx_r, dx_nxt;
  logic signed [31:0] dy_r, dy_nxt;
  logic               pressed;
  logic [1:0]         fingers;

  assign is_report = (evt.event_type == EV_SYN) && (evt.event_code == SYN_RPT);
  assign pressed   = (evt.event_value != 32'sd0);

  always_comb begin
    if (tool_r[TOOL_ONE]) begin
      fingers = 2'd1;
    end else if (tool_r[TOOL_TWO]) begin
      fingers = 2'd2;
    end else if (tool_r[TOOL_THREE]) begin
      fingers = 2'd3;
    end else begin
      fingers = 2'd0;
    end
  end

  always_comb begin
    x_nxt        = x_r;
    y_nxt        = y_r;
    pressure_nxt = pressure_r;
    width_nxt    = width_r;
    main_nxt     = main_r;
    extra_nxt    = extra_r;
    guest_nxt    = guest_r;
    tool_nxt     = tool_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    unique case (evt.event_type)
      EV_SYN: begin
        if (is_report) begin
          dx_nxt = 32'sd0;
          dy_nxt = 32'sd0;
        end
      end
      EV_KEY: begin
        case (evt.event_code) inside
          [KEY_EXTRA_FIRST:KEY_EXTRA_LAST]: extra_nxt[evt.event_code[2:0]] = pressed;
          KEY_LEFT:       main_nxt[MAIN_LEFT]   = pressed;
          KEY_RIGHT:      main_nxt[MAIN_RIGHT]  = pressed;
          KEY_MIDDLE:     main_nxt[MAIN_MIDDLE] = pressed;
          KEY_UP:         main_nxt[MAIN_UP]     = pressed;
          KEY_DOWN:       main_nxt[MAIN_DOWN]   = pressed;
          KEY_AUX_LEFT:   guest_nxt[AUX_LEFT]   = pressed;
          KEY_AUX_RIGHT:  guest_nxt[AUX_RIGHT]  = pressed;
          KEY_TOOL_ONE:   tool_nxt[TOOL_ONE]    = pressed;
          KEY_TOOL_TWO:   tool_nxt[TOOL_TWO]    = pressed;
          KEY_TOOL_THREE: tool_nxt[TOOL_THREE]  = pressed;
          KEY_TOUCH: begin
            if (!cfg.has_pressure_axis) begin
              pressure_nxt = pressed ? ({16'd0, cfg.touch_level} + 32'd1) : 32'sd0;
            end
          end
          default: ;
        endcase
      end
      EV_REL: begin
        case (evt.event_code)
          REL_X:   dx_nxt = evt.event_value;
          REL_Y:   dy_nxt = evt.event_value;
          default: ;
        endcase
      end
      EV_ABS: begin
        case (evt.event_code)
          ABS_X:     x_nxt        = evt.event_value;
          ABS_Y:     y_nxt        = evt.event_value;
          ABS_PRESS: pressure_nxt = evt.event_value;
          ABS_WIDTH: width_nxt    = evt.event_value;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r        <= 32'sd0;
      y_r        <= 32'sd0;
      pressure_r <= 32'sd0;
      width_r    <= 32'sd0;
      main_r     <= 5'd0;
      extra_r    <= 8'd0;
      guest_r    <= 2'd0;
      tool_r     <= 3'd0;
      dx_r       <= 32'sd0;
      dy_r       <= 32'sd0;
    end else if (go) begin
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      pressure_r <= pressure_nxt;
      width_r    <= width_nxt;
      main_r     <= main_nxt;
      extra_r    <= extra_nxt;
      guest_r    <= guest_nxt;
      tool_r     <= tool_nxt;
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
    end
  end

  // snapshot of the state before this event
  always_comb begin
    rep.rep_x             = x_r;
    rep.rep_y             = y_r;
    rep.rep_pressure      = pressure_r;
    rep.rep_width         = width_r;
    rep.rep_fingers       = fingers;
    rep.rep_main_buttons  = main_r;
    rep.rep_extra_buttons = extra_r;
    rep.rep_guest_buttons = guest_r;
    rep.rep_rel_dx        = dx_r;
    rep.rep_rel_dy        = dy_r;
  end

endmodule
`default_nettype wire

// ===== rtl/core/iesa_out_stage.sv =====
// result register: holds one report until the sink takes it
`default_nettype none
module iesa_out_stage
  import iesa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire rep_t rep_in,
  input  wire logic out_ready,
  output logic      out_valid,
  output rep_t      rep
);

  logic out_valid_r;
  logic out_valid_nxt;
  rep_t rep_r;

  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rep_r <= rep_in;
    end
  end

  assign out_valid = out_valid_r;
  assign rep       = rep_r;

endmodule
`default_nettype wire

// ===== rtl/core/input_event_state_accumulator.sv =====
// top level: touchpad event decoder with held state and sync reports
//
//   channel   direction  transaction
//   in_evt    sink       one event: event_type, event_code, event_value
//   out_rep   source     one report snapshot per sync report event
//   cfg_*     write      has_pressure_axis (index 0), touch_level (index 1)
//
// a report is valid after its sync event passes the input register and loads into the report register;
// one event per cycle, unless a report event waits for a full report register
// reset is synchronous on rst_n: held state zero, config to its defaults
// a report event waits in the input register while the report register is full
// other events pass through the decode stage even while a report waits
`default_nettype none
module input_event_state_accumulator
  import iesa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  iesa_evt_if.sink                    in_evt,
  iesa_rep_if.source                  out_rep,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic evt_valid;
  evt_t evt;
  logic go;
  logic is_report;
  rep_t rep_snap;
  logic out_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HAS_PRESSURE_AXIS: cfg_nxt.has_pressure_axis = cfg_data[0];
        CFG_TOUCH_LEVEL:       cfg_nxt.touch_level       = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.has_pressure_axis <= 1'b1;
      cfg_r.touch_level       <= 16'd30;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign go = evt_valid && (!is_report || !out_valid || out_rep.ready);

  iesa_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_evt.valid),
    .in_evt    (in_evt.payload),
    .in_ready  (in_evt.ready),
    .go        (go),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  iesa_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .evt       (evt),
    .go        (go),
    .is_report (is_report),
    .rep       (rep_snap)
  );

  iesa_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && is_report),
    .rep_in    (rep_snap),
    .out_ready (out_rep.ready),
    .out_valid (out_valid),
    .rep       (out_rep.payload)
  );

  assign out_rep.valid = out_valid;

endmodule
`default_nettype wire

// ===== verif/input_event_state_accumulator_test.sv =====
// testbench: touchpad event stream with a self-checking report scoreboard
module input_event_state_accumulator_test
  import iesa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_SHOWN      = 10;
  localparam int unsigned SETTLE_CYCLES  = 4;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  iesa_evt_if in_evt ();
  iesa_rep_if out_rep ();

  input_event_state_accumulator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_evt    (in_evt),
    .out_rep   (out_rep),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  // tracked touchpad state and register copies
  logic signed [31:0] trk_x = '0;
  logic signed [31:0] trk_y = '0;
  logic signed [31:0] trk_pressure = '0;
  logic signed [31:0] trk_width = '0;
  logic [4:0]         trk_main = '0;
  logic [7:0]         trk_extra = '0;
  logic [1:0]         trk_guest = '0;
  logic [2:0]         trk_tools = '0;
  logic signed [31:0] trk_dx = '0;
  logic signed [31:0] trk_dy = '0;
  logic               trk_has_pressure = 1'b1;
  logic [15:0]        trk_touch_level = 16'd30;

  rep_t        pending_reports[$];
  int unsigned events_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;
  int          burst_left = 0;

  function automatic evt_t make_event(logic [4:0] kind, logic [9:0] code, logic [31:0] value);
    evt_t e;
    e.event_type  = kind;
    e.event_code  = code;
    e.event_value = value;
    return e;
  endfunction

  function automatic void fold_event(evt_t e);
    rep_t snap;
    logic on;
    on = (e.event_value != 0);
    case (e.event_type)
      EV_SYN: begin
        if (e.event_code == SYN_RPT) begin
          snap.rep_x             = trk_x;
          snap.rep_y             = trk_y;
          snap.rep_pressure      = trk_pressure;
          snap.rep_width         = trk_width;
          snap.rep_main_buttons  = trk_main;
          snap.rep_extra_buttons = trk_extra;
          snap.rep_guest_buttons = trk_guest;
          snap.rep_rel_dx        = trk_dx;
          snap.rep_rel_dy        = trk_dy;
          if (trk_tools[TOOL_ONE]) snap.rep_fingers = 2'd1;
          else if (trk_tools[TOOL_TWO]) snap.rep_fingers = 2'd2;
          else if (trk_tools[TOOL_THREE]) snap.rep_fingers = 2'd3;
          else snap.rep_fingers = 2'd0;
          pending_reports.push_back(snap);
          trk_dx = '0;
          trk_dy = '0;
        end
      end
      EV_KEY: begin
        if (e.event_code >= KEY_EXTRA_FIRST && e.event_code <= KEY_EXTRA_LAST) begin
          trk_extra[3'(e.event_code - KEY_EXTRA_FIRST)] = on;
        end else begin
          case (e.event_code)
            KEY_LEFT:       trk_main[MAIN_LEFT] = on;
            KEY_RIGHT:      trk_main[MAIN_RIGHT] = on;
            KEY_MIDDLE:     trk_main[MAIN_MIDDLE] = on;
            KEY_UP:         trk_main[MAIN_UP] = on;
            KEY_DOWN:       trk_main[MAIN_DOWN] = on;
            KEY_AUX_LEFT:   trk_guest[AUX_LEFT] = on;
            KEY_AUX_RIGHT:  trk_guest[AUX_RIGHT] = on;
            KEY_TOOL_ONE:   trk_tools[TOOL_ONE] = on;
            KEY_TOOL_TWO:   trk_tools[TOOL_TWO] = on;
            KEY_TOOL_THREE: trk_tools[TOOL_THREE] = on;
            KEY_TOUCH: begin
              if (!trk_has_pressure)
                trk_pressure = on ? {16'd0, trk_touch_level} + 32'd1 : 32'd0;
            end
            default: ;
          endcase
        end
      end
      EV_REL: begin
        if (e.event_code == REL_X) trk_dx = e.event_value;
        else if (e.event_code == REL_Y) trk_dy = e.event_value;
      end
      EV_ABS: begin
        if (e.event_code == ABS_X) trk_x = e.event_value;
        else if (e.event_code == ABS_Y) trk_y = e.event_value;
        else if (e.event_code == ABS_PRESS) trk_pressure = e.event_value;
        else if (e.event_code == ABS_WIDTH) trk_width = e.event_value;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("report %0d field %s: expected %h, got %h", reports_checked, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : report_check
    rep_t want;
    if (rst_n && out_rep.valid && out_rep.ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("report %0d arrived with no sync event pending", reports_checked);
      end else begin
        want = pending_reports.pop_front();
        check_field("x", want.rep_x, out_rep.payload.rep_x);
        check_field("y", want.rep_y, out_rep.payload.rep_y);
        check_field("pressure", want.rep_pressure, out_rep.payload.rep_pressure);
        check_field("width", want.rep_width, out_rep.payload.rep_width);
        check_field("fingers", 32'(want.rep_fingers), 32'(out_rep.payload.rep_fingers));
        check_field("main_buttons", 32'(want.rep_main_buttons),
                    32'(out_rep.payload.rep_main_buttons));
        check_field("extra_buttons", 32'(want.rep_extra_buttons),
                    32'(out_rep.payload.rep_extra_buttons));
        check_field("guest_buttons", 32'(want.rep_guest_buttons),
                    32'(out_rep.payload.rep_guest_buttons));
        check_field("rel_dx", want.rep_rel_dx, out_rep.payload.rep_rel_dx);
        check_field("rel_dy", want.rep_rel_dy, out_rep.payload.rep_rel_dy);
      end
      reports_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_evt.valid && in_evt.ready) || (out_rep.valid && out_rep.ready) || cfg_we)
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // report receiver: runs of ready with stalls of mixed length
  initial begin : report_sink
    int run_left;
    int stall_left;
    run_left = 0;
    stall_left = 0;
    out_rep.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_left > 0) begin
        out_rep.ready <= 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        out_rep.ready <= 1'b0;
        stall_left--;
      end else begin
        out_rep.ready <= 1'($urandom_range(0, 1));
        run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 3);
      end
    end
  end

  task automatic send_event(evt_t e);
    if (burst_left <= 0) begin
      in_evt.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_evt.valid   <= 1'b1;
    in_evt.payload <= e;
    @(posedge clk);
    while (!in_evt.ready) @(posedge clk);
    fold_event(e);
    events_sent++;
    burst_left--;
  endtask

  task automatic settle();
    in_evt.valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HAS_PRESSURE_AXIS) trk_has_pressure = data[0];
    else trk_touch_level = data;
    cfg_writes++;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic evt_t random_event();
    int unsigned pick;
    logic [9:0]  code;
    logic [31:0] value;
    pick = $urandom_range(0, 99);
    value = random_value();
    if (pick < 14) begin
      return make_event(EV_SYN, SYN_RPT, value);
    end else if (pick < 50) begin
      case ($urandom_range(0, 12))
        0: code = KEY_LEFT;
        1: code = KEY_RIGHT;
        2: code = KEY_MIDDLE;
        3: code = KEY_UP;
        4: code = KEY_DOWN;
        5: code = KEY_AUX_LEFT;
        6: code = KEY_AUX_RIGHT;
        7: code = KEY_TOOL_ONE;
        8: code = KEY_TOOL_TWO;
        9: code = KEY_TOOL_THREE;
        10: code = KEY_TOUCH;
        default: code = KEY_EXTRA_FIRST + 10'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 9) < 4) value = '0;
      return make_event(EV_KEY, code, value);
    end else if (pick < 65) begin
      return make_event(EV_REL, $urandom_range(0, 1) ? REL_Y : REL_X, value);
    end else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0: code = ABS_X;
        1: code = ABS_Y;
        2: code = ABS_PRESS;
        default: code = ABS_WIDTH;
      endcase
      return make_event(EV_ABS, code, value);
    end
    return make_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)), $urandom);
  endfunction

  task automatic test_axes_and_keys();
    send_event(make_event(EV_ABS, ABS_X, 32'h7fff_ffff));
    send_event(make_event(EV_ABS, ABS_Y, 32'h8000_0000));
    send_event(make_event(EV_ABS, ABS_PRESS, 32'hffff_ffff));
    send_event(make_event(EV_ABS, ABS_WIDTH, 32'h8000_0000));
    send_event(make_event(EV_REL, REL_X, 32'h8000_0000));
    send_event(make_event(EV_REL, REL_Y, 32'h7fff_ffff));
    send_event(make_event(EV_KEY, KEY_TOUCH, 32'd1));
    send_event(make_event(EV_KEY, KEY_TOOL_THREE, 32'd1));
    send_event(make_event(EV_KEY, KEY_TOOL_TWO, 32'd1));
    send_event(make_event(EV_KEY, KEY_LEFT, 32'h8000_0000));
    send_event(make_event(EV_KEY, KEY_EXTRA_LAST, 32'hffff_ffff));
    send_event(make_event(EV_SYN, SYN_RPT + 10'd1, 32'd0));
    send_event(make_event(5'd31, 10'd767, 32'hffff_ffff));
    send_event(make_event(EV_SYN, SYN_RPT, 32'd0));
    send_event(make_event(EV_SYN, SYN_RPT, 32'hffff_ffff));
    send_event(make_event(EV_KEY, KEY_TOOL_ONE, 32'd1));
    send_event(make_event(EV_SYN, SYN_RPT, 32'd0));
  endtask

  task automatic test_touch_key();
    write_reg(CFG_HAS_PRESSURE_AXIS, '0);
    write_reg(CFG_TOUCH_LEVEL, 16'hffff);
    send_event(make_event(EV_KEY, KEY_TOUCH, 32'h8000_0000));
    send_event(make_event(EV_SYN, SYN_RPT, 32'd0));
    send_event(make_event(EV_KEY, KEY_TOUCH, 32'd0));
    send_event(make_event(EV_SYN, SYN_RPT, 32'd0));
    write_reg(CFG_TOUCH_LEVEL, 16'h0000);
    send_event(make_event(EV_KEY, KEY_TOUCH, 32'd1));
    send_event(make_event(EV_SYN, SYN_RPT, 32'd0));
    write_reg(CFG_HAS_PRESSURE_AXIS, 16'd1);
    send_event(make_event(EV_KEY, KEY_TOUCH, 32'd0));
    send_event(make_event(EV_SYN, SYN_RPT, 32'd0));
  endtask

  task automatic test_random_phase(logic has_axis, logic [15:0] touch_level, int count);
    write_reg(CFG_HAS_PRESSURE_AXIS, {15'd0, has_axis});
    write_reg(CFG_TOUCH_LEVEL, touch_level);
    repeat (count) send_event(random_event());
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_evt.valid   <= 1'b0;
    in_evt.payload <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_axes_and_keys();
    test_touch_key();
    test_random_phase(1'b1, 16'd30, 140);
    test_random_phase(1'b0, 16'h0000, 140);
    test_random_phase(1'b0, 16'hffff, 140);
    test_random_phase(1'b0, 16'($urandom_range(1, 65534)), 140);
    test_random_phase(1'b1, 16'($urandom_range(1, 65534)), 140);

    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d events and %0d reports across %0d register writes",
             events_sent, reports_checked, cfg_writes);
    $display("touch key, tool priority and motion clearing exercised; %0d field mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
